>>> design/epls_pkg.sv
// Shared types and constants for the event pair latency statistics block.
// Holds the table entry layout, the result layout and the status codes.
// No dependencies.
package epls_pkg;

  localparam int NUM_EVENTS_DEF = 10;

  localparam int EV_W   = 4;
  localparam int SEC_W  = 31;
  localparam int USEC_W = 20;
  localparam int CNT_W  = 31;
  localparam int VAL_W  = 32;
  localparam int GAP_W  = 12;

  localparam logic FUNC_NOTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [CNT_W-1:0]        INT_TOP      = 31'h7FFF_FFFF;
  localparam logic signed [21:0]      USEC_PER_SEC = 22'sd1000000;
  localparam logic [SEC_W-1:0]        MAX_GAP_SEC  = 31'd2146;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_ID       = 2'd1,
    ST_BAD_INTERVAL = 2'd2,
    ST_FIRST        = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [VAL_W-1:0] vmin;
    logic [CNT_W-1:0]        vmax;
    logic signed [VAL_W-1:0] avg;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    cnt:  '0,
    vmin: 32'sh7FFF_FFFF,
    vmax: '0,
    avg:  '0
  };

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] interval;
    entry_t                  entry;
  } result_t;

endpackage

>>> design/event_pair_latency_stats_core.sv
// Event pair latency monitor: per ordered pair min, max, count and running mean.
// Top level with the statistics memory, the interval arithmetic and a serial divider.
// Depends on epls_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): in_func selects a note (event id plus a
//   timestamp) or a read of the entry for the pair (in_from_id, in_event_id).
//   Result channel (out_valid/out_ready): one result item per input item, in order.
//   A note with a measured interval passes through the memory read, the multiply,
//   the divider setup, the 32-step restoring divider, the write-back and the output
//   load; a read passes through the memory read and the output load; a bad event
//   number or the first note goes straight to the output load. One item at a time:
//   a new item is accepted only once the last result has gone to the output register.
//   The table lives in one synchronous memory with a registered read. Per-entry
//   valid flops make an unwritten entry read as its cleared value, so reset
//   clears every entry and no clearing pass is needed.
//   When the receiver stalls, the finished result waits in the output register
//   and the block still accepts and works on the next item; that item's result
//   is held until the output register frees up.
module event_pair_latency_stats_core #(
  parameter int NUM_EVENTS = epls_pkg::NUM_EVENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [epls_pkg::EV_W-1:0]         in_event_id,
  input  logic [epls_pkg::EV_W-1:0]         in_from_id,
  input  logic [epls_pkg::SEC_W-1:0]        in_time_sec,
  input  logic [epls_pkg::USEC_W-1:0]       in_time_usec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [epls_pkg::VAL_W-1:0] out_interval_us,
  output logic [epls_pkg::CNT_W-1:0]        out_entry_count,
  output logic signed [epls_pkg::VAL_W-1:0] out_entry_min,
  output logic [epls_pkg::CNT_W-1:0]        out_entry_max,
  output logic signed [epls_pkg::VAL_W-1:0] out_entry_avg
);
  import epls_pkg::*;

  localparam int DEPTH  = NUM_EVENTS * NUM_EVENTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [EV_W:0] NUM_EV = (EV_W + 1)'(NUM_EVENTS);
  localparam int DIV_STEPS = VAL_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_PREP,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic                     out_valid_r;
  result_t                  out_r;
  result_t                  res_r;

  logic                     seen_r;
  logic [EV_W-1:0]          prev_ev_r;
  logic [SEC_W-1:0]         prev_sec_r;
  logic [USEC_W-1:0]        prev_usec_r;

  logic                     func_r;
  logic [EV_W-1:0]          ev_r;
  logic [SEC_W-1:0]         sec_r;
  logic [USEC_W-1:0]        usec_r;
  logic [ADDR_W-1:0]        addr_r;

  entry_t                   mem [DEPTH];
  entry_t                   rdata_r;
  entry_t                   ent_r;
  logic [DEPTH-1:0]         vld_r;

  logic                     ok_r;
  logic [GAP_W-1:0]         dsec_r;
  logic signed [21:0]       dusec_r;
  logic signed [VAL_W-1:0]  us_r;

  logic [VAL_W-1:0]         quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic [CNT_W-1:0]         dvsr_r;
  logic [DCNT_W-1:0]        div_cnt_r;
  logic                     neg_r;

  // Input side decode.
  logic                     in_acc;
  logic                     ev_bad;
  logic                     from_bad;
  logic                     in_bad;
  logic                     first_note;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     out_load;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign ev_bad     = ({1'b0, in_event_id} >= NUM_EV);
  assign from_bad   = ({1'b0, in_from_id} >= NUM_EV);
  assign in_bad     = ev_bad || ((in_func == FUNC_READ) && from_bad);
  assign first_note = !seen_r || ({1'b0, prev_ev_r} >= NUM_EV);
  assign rd_addr    = (in_func == FUNC_READ) ?
                      ADDR_W'(int'(in_from_id) * NUM_EVENTS + int'(in_event_id)) :
                      ADDR_W'(int'(prev_ev_r) * NUM_EVENTS + int'(in_event_id));
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Entry as read, with never-written entries showing their cleared value.
  entry_t                   ent_in;
  assign ent_in = vld_r[addr_r] ? rdata_r : ENTRY_RESET;

  // Interval measurement against the previous note.
  logic                     later;
  logic [SEC_W-1:0]         dsec_raw;
  logic [SEC_W-1:0]         dsec_adj;
  logic signed [21:0]       dusec_raw;
  logic signed [21:0]       dusec_adj;
  logic                     borrow;
  logic                     meas_ok;

  always_comb begin
    later     = (sec_r > prev_sec_r) || ((sec_r == prev_sec_r) && (usec_r > prev_usec_r));
    dsec_raw  = sec_r - prev_sec_r;
    dusec_raw = signed'({2'b00, usec_r}) - signed'({2'b00, prev_usec_r});
    borrow    = dusec_raw[21];
    dusec_adj = borrow ? (dusec_raw + USEC_PER_SEC) : dusec_raw;
    dsec_adj  = dsec_raw - SEC_W'(borrow);
    meas_ok   = later && (dsec_adj <= MAX_GAP_SEC);
  end

  // Whole seconds are below 4096 whenever the interval is valid.
  logic [VAL_W-1:0]         prod;
  logic signed [VAL_W-1:0]  us_calc;
  assign prod    = VAL_W'(dsec_r) * VAL_W'(USEC_PER_SEC);
  assign us_calc = ok_r ? signed'(prod + VAL_W'(dusec_r)) : -32'sd1;

  // Entry update ahead of the mean.
  logic [CNT_W-1:0]         cnt_new;
  logic signed [VAL_W-1:0]  vmin_new;
  logic [CNT_W-1:0]         vmax_new;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W-1:0]         diff_mag;

  always_comb begin
    cnt_new  = (ent_r.cnt == INT_TOP) ? ent_r.cnt : (ent_r.cnt + CNT_W'(1));
    vmin_new = (us_r < ent_r.vmin) ? us_r : ent_r.vmin;
    vmax_new = (us_r > signed'({1'b0, ent_r.vmax})) ? us_r[CNT_W-1:0] : ent_r.vmax;
    diff     = (VAL_W + 1)'(us_r) - (VAL_W + 1)'(ent_r.avg);
    diff_mag = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  end

  // One restoring division step per cycle on the magnitudes.
  logic [VAL_W-1:0]         rem_sh;
  logic [VAL_W-1:0]         rem_sub;
  logic                     q_bit;

  always_comb begin
    rem_sh  = {rem_r, quo_r[VAL_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr_r};
    q_bit   = (rem_sh >= {1'b0, dvsr_r});
  end

  // Mean update and write-back data.
  logic signed [VAL_W:0]    step;
  logic signed [VAL_W:0]    avg_sum;
  entry_t                   wdata;
  logic                     mem_we;

  always_comb begin
    step       = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
    avg_sum    = (VAL_W + 1)'(ent_r.avg) + step;
    wdata      = ent_r;
    wdata.avg  = signed'(avg_sum[VAL_W-1:0]);
    mem_we     = (state_r == S_WB);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wdata;
    end
    if (in_acc) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      prev_ev_r   <= '0;
      prev_sec_r  <= '0;
      prev_usec_r <= '0;
      vld_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_func;
            ev_r   <= in_event_id;
            sec_r  <= in_time_sec;
            usec_r <= in_time_usec;
            addr_r <= rd_addr;
            if (in_bad) begin
              res_r   <= '{status: ST_BAD_ID, interval: '0, entry: '0};
              state_r <= S_DONE;
            end else if (in_func == FUNC_READ) begin
              state_r <= S_LOAD;
            end else if (first_note) begin
              // The first note only records its event and time.
              seen_r      <= 1'b1;
              prev_ev_r   <= in_event_id;
              prev_sec_r  <= in_time_sec;
              prev_usec_r <= in_time_usec;
              res_r       <= '{status: ST_FIRST, interval: '0, entry: '0};
              state_r     <= S_DONE;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (func_r == FUNC_READ) begin
            res_r   <= '{status: ST_OK, interval: '0, entry: ent_in};
            state_r <= S_DONE;
          end else begin
            ent_r   <= ent_in;
            ok_r    <= meas_ok;
            dsec_r  <= dsec_adj[GAP_W-1:0];
            dusec_r <= dusec_adj;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          us_r    <= us_calc;
          state_r <= S_PREP;
        end
        S_PREP: begin
          ent_r.cnt  <= cnt_new;
          ent_r.vmin <= vmin_new;
          ent_r.vmax <= vmax_new;
          quo_r      <= diff_mag;
          rem_r      <= '0;
          dvsr_r     <= cnt_new;
          neg_r      <= diff[VAL_W];
          div_cnt_r  <= '0;
          state_r    <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          quo_r     <= {quo_r[VAL_W-2:0], q_bit};
          div_cnt_r <= div_cnt_r + DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          vld_r[addr_r] <= 1'b1;
          prev_ev_r     <= ev_r;
          prev_sec_r    <= sec_r;
          prev_usec_r   <= usec_r;
          res_r         <= '{status: (ok_r ? ST_OK : ST_BAD_INTERVAL),
                             interval: us_r, entry: wdata};
          state_r       <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_interval_us = out_r.interval;
  assign out_entry_count = out_r.entry.cnt;
  assign out_entry_min   = out_r.entry.vmin;
  assign out_entry_max   = out_r.entry.vmax;
  assign out_entry_avg   = out_r.entry.avg;

  // The partial remainder stays below the divisor at every step.
  a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvsr_r))
    else $error("divider remainder not below divisor");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && (div_cnt_r == DCNT_W'(DIV_STEPS - 1))) |=> (state_r == S_WB))
    else $error("divider did not finish after its last step");

  // An entry is written back only after at least one interval was counted.
  a_wb_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (ent_r.cnt != '0))
    else $error("write-back of an entry with zero count");

  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FIRST)) |->
      ((out_entry_count == '0) && (out_interval_us == '0)))
    else $error("first-event item carries entry data");

endmodule

>>> tb/event_pair_latency_stats_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_pair_latency_stats_core: note and read items
// with random handshake gaps, each result checked against an in-bench predictor.
// Depends on epls_pkg and the core RTL.
module event_pair_latency_stats_core_test;
  import epls_pkg::*;

  localparam int     NUM_EV       = NUM_EVENTS_DEF;
  localparam int     RANDOM_ITEMS = 1400;
  localparam int     HOLD_CYCLES  = 500;
  localparam int     STUCK_LIMIT  = 6000;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     MAX_REPORTS  = 10;
  localparam longint USEC_SEC     = 1000000;
  localparam longint SEC_TOP      = 64'h7FFF_FFFF;

  typedef struct {
    logic              func;
    logic [EV_W-1:0]   ev;
    logic [EV_W-1:0]   src;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
  } stamp_item_t;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic                     in_func      = FUNC_NOTE;
  logic [EV_W-1:0]          in_event_id  = '0;
  logic [EV_W-1:0]          in_from_id   = '0;
  logic [SEC_W-1:0]         in_time_sec  = '0;
  logic [USEC_W-1:0]        in_time_usec = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic [1:0]               out_status;
  logic signed [VAL_W-1:0]  out_interval_us;
  logic [CNT_W-1:0]         out_entry_count;
  logic signed [VAL_W-1:0]  out_entry_min;
  logic [CNT_W-1:0]         out_entry_max;
  logic signed [VAL_W-1:0]  out_entry_avg;

  event_pair_latency_stats_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_event_id     (in_event_id),
    .in_from_id      (in_from_id),
    .in_time_sec     (in_time_sec),
    .in_time_usec    (in_time_usec),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_interval_us (out_interval_us),
    .out_entry_count (out_entry_count),
    .out_entry_min   (out_entry_min),
    .out_entry_max   (out_entry_max),
    .out_entry_avg   (out_entry_avg)
  );

  always #4 clk = ~clk;

  // Predicted state of the block.
  entry_t             pair_stats [NUM_EV][NUM_EV];
  logic               have_prev;
  logic [EV_W-1:0]    last_ev;
  logic [SEC_W-1:0]   last_sec;
  logic [USEC_W-1:0]  last_usec;

  stamp_item_t pending_items [$];
  result_t     stats_due [$];
  stamp_item_t next_item;
  stamp_item_t taken_item;
  result_t     want;
  result_t     got;

  longint gen_sec;
  longint gen_usec;

  int items_taken  = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  int stall_hold   = 0;
  int mismatches   = 0;
  int total_items  = 0;
  int notes_done   = 0;
  int reads_done   = 0;
  int status_hits [4];
  logic held_off   = 1'b0;
  logic stuck;

  assign stuck = quiet_cycles >= STUCK_LIMIT;

  // Interval since the previous note, or -1 when not later or the gap is too large.
  function automatic logic signed [VAL_W-1:0] elapsed_us(input logic [SEC_W-1:0] sec,
      input logic [USEC_W-1:0] usec, output logic ok);
    longint dsec;
    longint dusec;
    ok = 1'b0;
    if (!(sec > last_sec || (sec == last_sec && usec > last_usec))) return -1;
    dsec  = longint'(sec) - longint'(last_sec);
    dusec = longint'(usec) - longint'(last_usec);
    if (dusec < 0) begin
      dusec += USEC_SEC;
      dsec  -= 1;
    end
    if (dsec > longint'(MAX_GAP_SEC)) return -1;
    ok = 1'b1;
    return VAL_W'(dusec + dsec * USEC_SEC);
  endfunction

  function automatic result_t predict_stats(input stamp_item_t it);
    result_t                 r;
    entry_t                  e;
    logic                    ok;
    logic signed [VAL_W-1:0] d;
    longint                  adj;
    r = '0;
    if (it.func == FUNC_READ) begin
      reads_done++;
      if (it.ev >= NUM_EV || it.src >= NUM_EV) r.status = ST_BAD_ID;
      else r.entry = pair_stats[it.src][it.ev];
    end else begin
      notes_done++;
      if (it.ev >= NUM_EV) begin
        r.status = ST_BAD_ID;
      end else begin
        if (!have_prev) begin
          r.status = ST_FIRST;
        end else begin
          d = elapsed_us(it.sec, it.usec, ok);
          e = pair_stats[last_ev][it.ev];
          if (d < e.vmin) e.vmin = d;
          if (d > $signed({1'b0, e.vmax})) e.vmax = d[CNT_W-1:0];
          if (e.cnt != INT_TOP) e.cnt++;
          // The mean truncates toward zero, as signed division does.
          adj = (longint'(d) - longint'(e.avg)) / longint'(e.cnt);
          e.avg = VAL_W'(longint'(e.avg) + adj);
          pair_stats[last_ev][it.ev] = e;
          if (ok) r.status = ST_OK;
          else r.status = ST_BAD_INTERVAL;
          r.interval = d;
          r.entry    = e;
        end
        have_prev = 1'b1;
        last_ev   = it.ev;
        last_sec  = it.sec;
        last_usec = it.usec;
      end
    end
    status_hits[r.status]++;
    return r;
  endfunction

  task automatic add_note(input int ev, input longint sec, input longint usec);
    stamp_item_t it;
    it.func = FUNC_NOTE;
    it.ev   = EV_W'(ev);
    it.src  = EV_W'($urandom_range(0, 15));
    it.sec  = SEC_W'(sec);
    it.usec = USEC_W'(usec);
    pending_items.push_back(it);
  endtask

  task automatic add_read(input int ev, input int src);
    stamp_item_t it;
    it.func = FUNC_READ;
    it.ev   = EV_W'(ev);
    it.src  = EV_W'(src);
    it.sec  = SEC_W'($urandom);
    it.usec = USEC_W'($urandom);
    pending_items.push_back(it);
  endtask

  // Moves the time cursor forward by du microseconds and notes the event there.
  task automatic add_later_note(input int ev, input longint du);
    gen_usec += du;
    gen_sec  += gen_usec / USEC_SEC;
    gen_usec  = gen_usec % USEC_SEC;
    if (gen_sec > SEC_TOP) gen_sec = $urandom_range(0, 5000);
    add_note(ev, gen_sec, gen_usec);
  endtask

  // Sender: offers the next pending item, idling now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 &&
          ((items_taken >= 600 && items_taken < 800) || $urandom_range(0, 99) >= 16)) begin
        next_item     = pending_items.pop_front();
        in_valid     <= 1'b1;
        in_func      <= next_item.func;
        in_event_id  <= next_item.ev;
        in_from_id   <= next_item.src;
        in_time_sec  <= next_item.sec;
        in_time_usec <= next_item.usec;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_off && results_seen >= 250) begin
      held_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen >= 600 && results_seen < 800) ||
                   $urandom_range(0, 99) >= 16;
    end
  end

  // Result check first, then prediction for the item taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got.status         = status_t'(out_status);
        got.interval       = out_interval_us;
        got.entry.cnt      = out_entry_count;
        got.entry.vmin     = out_entry_min;
        got.entry.vmax     = out_entry_max;
        got.entry.avg      = out_entry_avg;
        if (stats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected result item %0d: status %0d interval %0d", results_seen,
                     got.status, got.interval);
        end else begin
          want = stats_due.pop_front();
          if (got.status !== want.status || got.interval !== want.interval ||
              got.entry.cnt !== want.entry.cnt || got.entry.vmin !== want.entry.vmin ||
              got.entry.vmax !== want.entry.vmax || got.entry.avg !== want.entry.avg) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Result %0d expected status %0d interval %0d count %0d min %0d max %0d avg %0d",
                       results_seen, want.status, want.interval, want.entry.cnt,
                       want.entry.vmin, want.entry.vmax, want.entry.avg);
              $display("Result %0d got      status %0d interval %0d count %0d min %0d max %0d avg %0d",
                       results_seen, got.status, got.interval, got.entry.cnt,
                       got.entry.vmin, got.entry.vmax, got.entry.avg);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        items_taken <= items_taken + 1;
        taken_item = '{in_func, in_event_id, in_from_id, in_time_sec, in_time_usec};
        stats_due.push_back(predict_stats(taken_item));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (hold_left != 0 && in_valid && !in_ready) stall_hold <= stall_hold + 1;
    end
  end

  initial begin
    int     pick;
    int     dst;
    int     src;
    longint du;
    longint back_total;

    for (int i = 0; i < NUM_EV; i++)
      for (int j = 0; j < NUM_EV; j++) pair_stats[i][j] = ENTRY_RESET;
    have_prev = 1'b0;
    last_ev   = '0;
    last_sec  = '0;
    last_usec = '0;
    for (int i = 0; i < 4; i++) status_hits[i] = 0;

    // Directed part: reset entries, bad ids, first note, gap limits, borrows.
    add_read(0, 0);
    add_note(15, SEC_TOP, 1048575);
    add_read(3, 12);
    add_read(10, 0);
    add_note(0, 0, 0);
    add_note(0, 0, 0);
    add_note(1, 0, 1);
    add_note(9, 2146, 1);
    add_note(9, 4293, 0);
    add_note(9, 6440, 1);
    add_note(5, 6440, 1048575);
    add_note(5, 6441, 0);
    add_note(2, SEC_TOP, 1048575);
    add_note(2, 0, 0);
    add_note(3, 0, 999999);
    add_note(3, 1, 0);
    add_note(3, 1, 2);
    add_note(3, 1, 5);
    add_note(10, 5, 5);
    add_read(0, 0);
    add_read(1, 0);
    add_read(9, 9);
    add_read(5, 5);
    add_read(15, 15);
    add_read(2, 5);
    gen_sec  = 1;
    gen_usec = 5;

    // Random part: mostly well-ordered notes on a few busy pairs, mixed with noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      dst  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, NUM_EV - 1);
      src  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, NUM_EV - 1);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: du = $urandom_range(1, 2000);
          6, 7:             du = $urandom_range(1, 10000000);
          8:                du = longint'($urandom_range(0, 2146)) * USEC_SEC +
                                 $urandom_range(1, 999999);
          default:          du = 2146 * USEC_SEC + $urandom_range(999000, 1001000);
        endcase
        add_later_note(dst, du);
      end else if (pick < 75) begin
        add_read(dst, src);
      end else if (pick < 79) begin
        if ($urandom_range(0, 1)) add_read($urandom_range(NUM_EV, 15), $urandom_range(0, 15));
        else add_read($urandom_range(0, 15), $urandom_range(NUM_EV, 15));
      end else if (pick < 84) begin
        add_note($urandom_range(NUM_EV, 15), $urandom & SEC_TOP, $urandom_range(0, 1048575));
      end else if (pick < 89) begin
        // Same or earlier time than the last note.
        back_total = gen_sec * USEC_SEC + gen_usec - $urandom_range(0, 3000000);
        if (back_total < 0) back_total = 0;
        gen_sec  = back_total / USEC_SEC;
        gen_usec = back_total % USEC_SEC;
        add_note(dst, gen_sec, gen_usec);
      end else if (pick < 93) begin
        add_later_note(dst, longint'($urandom_range(2148, 1000000)) * USEC_SEC +
                            $urandom_range(0, 999999));
      end else if (pick < 97) begin
        // Microseconds above one second, taken as given by the block.
        if (gen_sec + 2 > SEC_TOP) gen_sec = 0;
        gen_sec  = gen_sec + $urandom_range(0, 1);
        gen_usec = $urandom_range(1000000, 1048575);
        add_note(dst, gen_sec, gen_usec);
        gen_sec  = gen_sec + 1;
        gen_usec = gen_usec - USEC_SEC;
      end else begin
        gen_sec  = $urandom & SEC_TOP;
        gen_usec = $urandom_range(0, 999999);
        add_note(dst, gen_sec, gen_usec);
      end
    end
    total_items = pending_items.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (!stuck && !(items_taken == total_items && stats_due.size() == 0)) @(posedge clk);
    if (!stuck) repeat (DRAIN_CYCLES) @(posedge clk);
    if (stuck) $display("Timed out after %0d cycles without a handshake.", quiet_cycles);

    $display("Ran %0d notes and %0d reads: %0d ok, %0d bad id, %0d invalid interval, %0d first.",
             notes_done, reads_done, status_hits[ST_OK], status_hits[ST_BAD_ID],
             status_hits[ST_BAD_INTERVAL], status_hits[ST_FIRST]);
    $display("Receiver hold-off kept the input stalled for %0d cycles; %0d mismatches.",
             stall_hold, mismatches);
    if (!stuck && mismatches == 0 && stats_due.size() == 0) begin
      $display("event_pair_latency_stats_core_test OK");
    end else begin
      $display("event_pair_latency_stats_core_test NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/epls_pkg.sv
design/event_pair_latency_stats_core.sv
tb/event_pair_latency_stats_core_test.sv
